// File: rtl/core/launcher_spin_feed_sequencer_top_defines.svh
// ----------------------------------------------------------------------------
// Launcher spin/feed sequencer assertion macros
// Shared property shorthands for the checker; clocked on aclk, off in reset.
// ----------------------------------------------------------------------------
`ifndef LAUNCHER_SPIN_FEED_SEQUENCER_TOP_DEFINES_SVH
`define LAUNCHER_SPIN_FEED_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication
`define LSFS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define LSFS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/lsfs_pkg.sv
// ----------------------------------------------------------------------------
// Launcher spin/feed sequencer package
// Transaction types, register indexes, state codes and fixed thresholds.
// ----------------------------------------------------------------------------
package lsfs_pkg;

    // Run detection threshold on current magnitude
    localparam int RUN_CURRENT_MIN = 10;
    localparam logic [16:0] RUN_MIN_MAG = 17'(RUN_CURRENT_MIN);

    // Feeder speed levels
    localparam int FEED_LEVELS = 3;
    localparam logic [1:0] FEED_LEVEL_MAX = 2'(FEED_LEVELS - 1);

    // Reset value of the command expiry limit
    localparam logic [15:0] EXPIRE_RESET = 16'd100;

    // Configuration register indexes
    localparam logic [2:0] CFG_LOW_SPEED    = 3'd0;
    localparam logic [2:0] CFG_HIGH_SPEED   = 3'd1;
    localparam logic [2:0] CFG_EXPIRE_LIMIT = 3'd2;
    localparam logic [2:0] CFG_HEAT_FLOOR   = 3'd3;
    localparam logic [2:0] CFG_FEED_SPEED_0 = 3'd4;
    localparam logic [2:0] CFG_FEED_SPEED_1 = 3'd5;
    localparam logic [2:0] CFG_FEED_SPEED_2 = 3'd6;

    // Speed request codes
    localparam logic [1:0] SPEED_STOP = 2'd0;
    localparam logic [1:0] SPEED_LOW  = 2'd1;
    localparam logic [1:0] SPEED_HIGH = 2'd2;

    // Fire request codes
    localparam logic [1:0] FIRE_HOLD = 2'd0;
    localparam logic [1:0] FIRE_SHOT = 2'd1;

    // Reported sequencer state codes
    localparam logic [2:0] SEQ_WHEEL_LOCK = 3'd0;
    localparam logic [2:0] SEQ_WHEEL_RUN  = 3'd1;
    localparam logic [2:0] SEQ_FEED_LOCK  = 3'd2;
    localparam logic [2:0] SEQ_FEED_RUN   = 3'd3;
    localparam logic [2:0] SEQ_UNDEF      = 3'd4;

    // Internal one-hot sequencer state
    typedef enum logic [4:0] {
        ST_WHEEL_LOCK = 5'b00001,
        ST_WHEEL_RUN  = 5'b00010,
        ST_FEED_LOCK  = 5'b00100,
        ST_FEED_RUN   = 5'b01000,
        ST_UNDEF      = 5'b10000
    } seq_state_t;

    // Command tick transaction
    typedef struct packed {
        logic        [15:0] cmd_age;
        logic        [15:0] rest_heat;
        logic        [1:0]  speed_request;
        logic        [1:0]  fire_request;
        logic        [1:0]  feed_level;
        logic signed [15:0] cur_left_up;
        logic signed [15:0] cur_left_down;
        logic signed [15:0] cur_right_up;
        logic signed [15:0] cur_right_down;
        logic signed [15:0] cur_feed_down;
        logic signed [15:0] cur_feed_up;
    } in_t;

    // Result transaction
    typedef struct packed {
        logic        [2:0]  seq_state;
        logic signed [15:0] wheel_setpoint;
        logic signed [15:0] feed_setpoint;
        logic               wheels_spinning;
        logic               feeder_spinning;
    } out_t;

endpackage

// File: rtl/core/launcher_spin_feed_sequencer_top.sv
// Timing: the input register loads at the accepting edge and the result
// register loads from it once the result slot is free.
// Throughput: 1 transaction per cycle while the result side does not stall;
// the sequencer state loop closes through the step logic between the two registers.
// Reset: synchronous active-low aresetn empties both registers, sets the
// sequencer to wheels locked, clears setpoints and loads register defaults.
// ----------------------------------------------------------------------------
// Launcher spin/feed sequencer
// Run detection on six motor currents and a five-state wheel/feeder
// sequencer with held wheel and feeder setpoints.
// ----------------------------------------------------------------------------
module launcher_spin_feed_sequencer_top
    import lsfs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // command ticks
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Magnitude at 17 bits so the most negative current counts in full
    function automatic logic motor_runs(input logic signed [15:0] cur);
        logic signed [16:0] ext;
        logic        [16:0] mag;
        ext = 17'(cur);
        mag = ext[16] ? 17'(-ext) : 17'(ext);
        return mag >= RUN_MIN_MAG;
    endfunction

    function automatic logic [2:0] state_code(input seq_state_t st);
        logic [2:0] code;
        unique case (st)
            ST_WHEEL_LOCK: code = SEQ_WHEEL_LOCK;
            ST_WHEEL_RUN:  code = SEQ_WHEEL_RUN;
            ST_FEED_LOCK:  code = SEQ_FEED_LOCK;
            ST_FEED_RUN:   code = SEQ_FEED_RUN;
            default:       code = SEQ_UNDEF;
        endcase
        return code;
    endfunction

    // Configuration registers
    logic        [14:0] low_speed_reg;
    logic        [14:0] high_speed_reg;
    logic        [15:0] expire_limit_reg;
    logic        [15:0] heat_floor_reg;
    logic signed [15:0] feed_speed_reg [FEED_LEVELS];

    // Pipeline registers
    logic in_valid_reg;
    in_t  in_data_reg;
    logic out_valid_reg;
    out_t out_data_reg;

    // Sequencer state
    seq_state_t         seq_reg,        seq_next;
    logic signed [15:0] wheel_cmd_reg,  wheel_cmd_next;
    logic signed [15:0] feed_cmd_reg,   feed_cmd_next;

    logic               advance;
    logic               wheels;
    logic               feeder;
    logic               stale;
    logic signed [15:0] wheel_start;
    logic        [1:0]  level_sat;
    seq_state_t         seq_cur;

    assign cfg_ready = 1'b1;

    // Configuration write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_speed_reg    <= '0;
            high_speed_reg   <= '0;
            expire_limit_reg <= EXPIRE_RESET;
            heat_floor_reg   <= '0;
            for (int i = 0; i < FEED_LEVELS; i++) begin
                feed_speed_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_LOW_SPEED:    low_speed_reg    <= cfg_data[14:0];
                CFG_HIGH_SPEED:   high_speed_reg   <= cfg_data[14:0];
                CFG_EXPIRE_LIMIT: expire_limit_reg <= cfg_data;
                CFG_HEAT_FLOOR:   heat_floor_reg   <= cfg_data;
                CFG_FEED_SPEED_0: feed_speed_reg[0] <= signed'(cfg_data);
                CFG_FEED_SPEED_1: feed_speed_reg[1] <= signed'(cfg_data);
                CFG_FEED_SPEED_2: feed_speed_reg[2] <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    // Handshake: input register moves on whenever the result slot frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Run detection
    assign wheels = motor_runs(in_data_reg.cur_left_up)
                 && motor_runs(in_data_reg.cur_left_down)
                 && motor_runs(in_data_reg.cur_right_up)
                 && motor_runs(in_data_reg.cur_right_down);
    assign feeder = motor_runs(in_data_reg.cur_feed_down)
                 && motor_runs(in_data_reg.cur_feed_up);

    assign stale = (in_data_reg.cmd_age > expire_limit_reg)
                || (in_data_reg.rest_heat < heat_floor_reg);

    // Wheel start value; other requests keep the held setpoint
    always_comb begin
        priority if (in_data_reg.speed_request == SPEED_LOW) begin
            wheel_start = signed'({1'b0, low_speed_reg});
        end else if (in_data_reg.speed_request == SPEED_HIGH) begin
            wheel_start = signed'({1'b0, high_speed_reg});
        end else begin
            wheel_start = wheel_cmd_reg;
        end
    end

    assign level_sat = (in_data_reg.feed_level > FEED_LEVEL_MAX)
                     ? FEED_LEVEL_MAX : in_data_reg.feed_level;

    // A stop request forces undefined, handled in the same step
    assign seq_cur = (in_data_reg.speed_request == SPEED_STOP) ? ST_UNDEF : seq_reg;

    // Sequencer step
    always_comb begin
        seq_next       = seq_reg;
        wheel_cmd_next = wheel_cmd_reg;
        feed_cmd_next  = feed_cmd_reg;
        if (stale) begin
            // reduced safe path
            unique case (seq_reg)
                ST_FEED_RUN: begin
                    if (feeder) begin
                        feed_cmd_next = '0;
                    end
                end
                ST_FEED_LOCK:  seq_next = ST_WHEEL_RUN;
                ST_WHEEL_LOCK: wheel_cmd_next = wheel_start;
                ST_UNDEF:      seq_next = ST_WHEEL_LOCK;
                default: ;
            endcase
        end else begin
            unique case (seq_cur)
                ST_WHEEL_LOCK: begin
                    seq_next = ST_WHEEL_LOCK;
                    priority if (feeder) begin
                        seq_next = ST_UNDEF;
                    end else if (!wheels) begin
                        wheel_cmd_next = wheel_start;
                    end else begin
                        seq_next = ST_WHEEL_RUN;
                    end
                end
                ST_WHEEL_RUN: begin
                    priority if (feeder) begin
                        seq_next = ST_UNDEF;
                    end else if (wheels) begin
                        seq_next = ST_FEED_LOCK;
                    end else begin
                        seq_next = ST_WHEEL_LOCK;
                    end
                end
                ST_FEED_LOCK: begin
                    seq_next = ST_FEED_LOCK;
                    priority if (!wheels) begin
                        seq_next = ST_WHEEL_LOCK;
                    end else if (feeder) begin
                        seq_next = ST_FEED_RUN;
                    end else if (in_data_reg.fire_request == FIRE_SHOT) begin
                        feed_cmd_next = feed_speed_reg[level_sat];
                    end else if (in_data_reg.fire_request != FIRE_HOLD) begin
                        seq_next = ST_UNDEF;
                    end
                end
                ST_FEED_RUN: begin
                    seq_next = ST_FEED_RUN;
                    priority if (!wheels) begin
                        seq_next = ST_UNDEF;
                    end else if (!feeder) begin
                        seq_next = ST_FEED_LOCK;
                    end else if (in_data_reg.fire_request == FIRE_HOLD) begin
                        feed_cmd_next = '0;
                    end else if (in_data_reg.fire_request != FIRE_SHOT) begin
                        seq_next = ST_UNDEF;
                    end
                end
                ST_UNDEF: begin
                    seq_next = ST_UNDEF;
                    priority if (!wheels && !feeder) begin
                        seq_next = ST_WHEEL_LOCK;
                    end else if (feeder) begin
                        feed_cmd_next = '0;
                    end else begin
                        wheel_cmd_next = '0;
                    end
                end
                default: seq_next = ST_UNDEF;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // State and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg       <= ST_WHEEL_LOCK;
            wheel_cmd_reg <= '0;
            feed_cmd_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                seq_reg       <= seq_next;
                wheel_cmd_reg <= wheel_cmd_next;
                feed_cmd_reg  <= feed_cmd_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg.seq_state       <= state_code(seq_next);
            out_data_reg.wheel_setpoint  <= wheel_cmd_next;
            out_data_reg.feed_setpoint   <= feed_cmd_next;
            out_data_reg.wheels_spinning <= wheels;
            out_data_reg.feeder_spinning <= feeder;
        end
    end

endmodule

// File: rtl/core/lsfs_checker.sv
// ----------------------------------------------------------------------------
// Launcher spin/feed sequencer checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "launcher_spin_feed_sequencer_top_defines.svh"

module lsfs_checker
    import lsfs_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // Stalled result transaction holds
    `LSFS_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // A fresh result follows an accepted transaction through the input and result registers
    `LSFS_ASSERT_IMP(a_out_latency, $rose(m_valid), $past(s_valid && s_ready && aresetn, 2), "result without a matching input transaction")

    // Feed locked is only ever reported with the wheels spinning
    `LSFS_ASSERT_IMP(a_feed_lock_wheels, m_valid && (m_data.seq_state == SEQ_FEED_LOCK), m_data.wheels_spinning, "feed locked without spinning wheels")

endmodule

bind launcher_spin_feed_sequencer_top lsfs_checker u_lsfs_checker (.*);

// File: tb/sv/launcher_spin_feed_sequencer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Launcher spin/feed sequencer testbench
// Drives command ticks and register writes into the sequencer and predicts
// every status transaction in lockstep: run detection, safe path, stop
// requests, the five-state walk and the held setpoints. Both handshakes see
// random gaps, one quiet stretch and one long result hold-off.
// ----------------------------------------------------------------------------
module launcher_spin_feed_sequencer_top_tb;
    import lsfs_pkg::*;

    // Request codes the package leaves unnamed
    localparam logic [1:0] SPEED_ODD   = 2'd3;
    localparam logic [1:0] FIRE_ODD    = 2'd2;
    localparam logic [1:0] FIRE_ODD_HI = 2'd3;

    localparam int HOLD_CYCLES = 60;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // Shadow registers and sequencer state
    logic [14:0]        low_speed_q  = '0;
    logic [14:0]        high_speed_q = '0;
    logic [15:0]        expire_q     = EXPIRE_RESET;
    logic [15:0]        heat_floor_q = '0;
    logic signed [15:0] feed_speed_q [3] = '{default: '0};
    logic [2:0]         seq_q   = SEQ_WHEEL_LOCK;
    logic signed [15:0] wheel_q = '0;
    logic signed [15:0] feed_q  = '0;

    // Status transactions still owed by the block, oldest first
    out_t due_status [$];

    bit          gaps_on      = 1'b1;
    bit          hold_results = 1'b0;
    int unsigned mismatches   = 0;
    int unsigned n_ticks      = 0;
    int unsigned n_safe       = 0;
    int unsigned n_results    = 0;
    int unsigned n_writes     = 0;
    int unsigned state_hits [5] = '{default: 0};
    int unsigned stall_cycles = 0;

    launcher_spin_feed_sequencer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Current magnitude taken wide, so the most negative code still runs
    function automatic bit spins(logic signed [15:0] cur);
        int mag;
        mag = cur;
        if (mag < 0) mag = -mag;
        return mag >= RUN_CURRENT_MIN;
    endfunction

    // Wheel start; an unknown speed request keeps the held setpoint
    function automatic void spin_up(logic [1:0] req);
        if (req == SPEED_LOW) wheel_q = {1'b0, low_speed_q};
        else if (req == SPEED_HIGH) wheel_q = {1'b0, high_speed_q};
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            CFG_LOW_SPEED:    low_speed_q     = val[14:0];
            CFG_HIGH_SPEED:   high_speed_q    = val[14:0];
            CFG_EXPIRE_LIMIT: expire_q        = val;
            CFG_HEAT_FLOOR:   heat_floor_q    = val;
            CFG_FEED_SPEED_0: feed_speed_q[0] = val;
            CFG_FEED_SPEED_1: feed_speed_q[1] = val;
            CFG_FEED_SPEED_2: feed_speed_q[2] = val;
            default: ;
        endcase
    endfunction

    // One command tick through the sequencer; returns the status it reports
    function automatic out_t sequencer_step(in_t t);
        out_t r;
        bit   wheels;
        bit   feeder;
        wheels = spins(t.cur_left_up) && spins(t.cur_left_down) &&
                 spins(t.cur_right_up) && spins(t.cur_right_down);
        feeder = spins(t.cur_feed_down) && spins(t.cur_feed_up);
        if (t.cmd_age > expire_q || t.rest_heat < heat_floor_q) begin
            // stale command or low heat: reduced step
            n_safe++;
            case (seq_q)
                SEQ_FEED_RUN:   if (feeder) feed_q = '0;
                SEQ_FEED_LOCK:  seq_q = SEQ_WHEEL_RUN;
                SEQ_WHEEL_LOCK: spin_up(t.speed_request);
                SEQ_UNDEF:      seq_q = SEQ_WHEEL_LOCK;
                default: ;
            endcase
        end else begin
            // stop forces undefined, handled in the same step
            if (t.speed_request == SPEED_STOP) seq_q = SEQ_UNDEF;
            case (seq_q)
                SEQ_WHEEL_LOCK: begin
                    if (feeder) seq_q = SEQ_UNDEF;
                    else if (!wheels) spin_up(t.speed_request);
                    else seq_q = SEQ_WHEEL_RUN;
                end
                SEQ_WHEEL_RUN: begin
                    if (feeder) seq_q = SEQ_UNDEF;
                    else seq_q = wheels ? SEQ_FEED_LOCK : SEQ_WHEEL_LOCK;
                end
                SEQ_FEED_LOCK: begin
                    if (!wheels) seq_q = SEQ_WHEEL_LOCK;
                    else if (feeder) seq_q = SEQ_FEED_RUN;
                    else if (t.fire_request == FIRE_SHOT)
                        feed_q = feed_speed_q[(t.feed_level > FEED_LEVEL_MAX) ?
                                              FEED_LEVEL_MAX : t.feed_level];
                    else if (t.fire_request != FIRE_HOLD) seq_q = SEQ_UNDEF;
                end
                SEQ_FEED_RUN: begin
                    if (!wheels) seq_q = SEQ_UNDEF;
                    else if (!feeder) seq_q = SEQ_FEED_LOCK;
                    else if (t.fire_request == FIRE_HOLD) feed_q = '0;
                    else if (t.fire_request != FIRE_SHOT) seq_q = SEQ_UNDEF;
                end
                SEQ_UNDEF: begin
                    if (!wheels && !feeder) seq_q = SEQ_WHEEL_LOCK;
                    else if (feeder) feed_q = '0;
                    else wheel_q = '0;
                end
                default: seq_q = SEQ_UNDEF;
            endcase
        end
        r.seq_state       = seq_q;
        r.wheel_setpoint  = wheel_q;
        r.feed_setpoint   = feed_q;
        r.wheels_spinning = wheels;
        r.feeder_spinning = feeder;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
            note_mismatch($sformatf("%s expected %0d, got %0d (result %0d)",
                                    name, want, got, n_results));
    endfunction

    always @(posedge aclk) begin : check_status
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (m_data.seq_state <= SEQ_UNDEF) state_hits[m_data.seq_state]++;
            if (due_status.size() == 0) begin
                note_mismatch($sformatf("status transaction with nothing owed, state %0d",
                                        m_data.seq_state));
            end else begin
                want = due_status.pop_front();
                check_field("seq_state", want.seq_state, m_data.seq_state);
                check_field("wheel_setpoint", want.wheel_setpoint, m_data.wheel_setpoint);
                check_field("feed_setpoint", want.feed_setpoint, m_data.feed_setpoint);
                check_field("wheels_spinning", want.wheels_spinning,
                            m_data.wheels_spinning);
                check_field("feeder_spinning", want.feeder_spinning,
                            m_data.feeder_spinning);
            end
            n_results++;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random ready, optional long hold-off
    // ------------------------------------------------------------------
    initial begin : result_sink
        int held;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_results) begin
                m_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(negedge aclk);
                hold_results = 1'b0;
            end
            m_ready <= !gaps_on || ($urandom_range(0, 99) >= 20);
        end
    end

    // Watchdog: ends the run after too many cycles without any transaction
    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("launcher_spin_feed_sequencer_top_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers; every task is entered and left at a falling edge
    // ------------------------------------------------------------------
    task automatic send_tick(input in_t t);
        int gap;
        if (gaps_on && $urandom_range(0, 99) < 12) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        due_status.push_back(sequencer_step(t));
        n_ticks++;
        @(negedge aclk);
    endtask

    // Register writes only once every owed status has come back
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        s_valid <= 1'b0;
        while (due_status.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, val);
        n_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_regs(input logic [15:0] low, input logic [15:0] high,
                             input logic [15:0] expire, input logic [15:0] floor_heat,
                             input logic [15:0] f0, input logic [15:0] f1,
                             input logic [15:0] f2);
        write_reg(CFG_LOW_SPEED, low);
        write_reg(CFG_HIGH_SPEED, high);
        write_reg(CFG_EXPIRE_LIMIT, expire);
        write_reg(CFG_HEAT_FLOOR, floor_heat);
        write_reg(CFG_FEED_SPEED_0, f0);
        write_reg(CFG_FEED_SPEED_1, f1);
        write_reg(CFG_FEED_SPEED_2, f2);
    endtask

    // Wheel currents follow the mounting sign pattern; both feeders alike
    function automatic in_t make_tick(logic [15:0] age, logic [15:0] heat,
                                      logic [1:0] spd, logic [1:0] fire,
                                      logic [1:0] lvl, logic signed [15:0] wcur,
                                      logic signed [15:0] fcur);
        in_t t;
        t.cmd_age        = age;
        t.rest_heat      = heat;
        t.speed_request  = spd;
        t.fire_request   = fire;
        t.feed_level     = lvl;
        t.cur_left_up    = -wcur;
        t.cur_left_down  = wcur;
        t.cur_right_up   = wcur;
        t.cur_right_down = -wcur;
        t.cur_feed_down  = fcur;
        t.cur_feed_up    = fcur;
        return t;
    endfunction

    // Current that runs or idles, with threshold edges and raw noise
    function automatic logic signed [15:0] pick_current(bit run);
        logic signed [15:0] c;
        case ($urandom_range(0, 9))
            0: c = run ? 16'sh8000 : 16'sd0;
            1: c = run ? 16'(RUN_CURRENT_MIN) : 16'(RUN_CURRENT_MIN - 1);
            2: c = 16'($urandom());
            default: c = run ? 16'($urandom_range(RUN_CURRENT_MIN, 32767)) :
                               16'($urandom_range(0, RUN_CURRENT_MIN - 1));
        endcase
        if ($urandom_range(0, 1)) c = -c;
        return c;
    endfunction

    // Mostly fresh, warm commands that let the sequencer climb to feeding
    function automatic in_t random_tick();
        in_t t;
        bit  fresh;
        bit  warm;
        int  r;
        int  dud;
        logic signed [15:0] w [4];
        fresh = ($urandom_range(0, 99) < 85) || (expire_q == 16'hFFFF);
        warm  = ($urandom_range(0, 99) < 88) || (heat_floor_q == 16'h0000);
        t.cmd_age   = fresh ? 16'($urandom_range(0, expire_q)) :
                              16'($urandom_range(expire_q + 1, 65535));
        t.rest_heat = warm ? 16'($urandom_range(heat_floor_q, 65535)) :
                             16'($urandom_range(0, heat_floor_q - 1));
        r = $urandom_range(0, 99);
        t.speed_request = (r < 8) ? SPEED_STOP : (r < 48) ? SPEED_LOW :
                          (r < 88) ? SPEED_HIGH : SPEED_ODD;
        r = $urandom_range(0, 99);
        t.fire_request = (r < 40) ? FIRE_HOLD : (r < 85) ? FIRE_SHOT :
                         (r < 93) ? FIRE_ODD : FIRE_ODD_HI;
        t.feed_level = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 65) begin
            foreach (w[i]) w[i] = pick_current(1'b1);
        end else begin
            dud = $urandom_range(0, 3);
            foreach (w[i]) w[i] = pick_current((i != dud) && $urandom_range(0, 1));
        end
        t.cur_left_up    = w[0];
        t.cur_left_down  = w[1];
        t.cur_right_up   = w[2];
        t.cur_right_down = w[3];
        if ($urandom_range(0, 99) < 40) begin
            t.cur_feed_down = pick_current(1'b1);
            t.cur_feed_up   = pick_current(1'b1);
        end else begin
            t.cur_feed_down = pick_current($urandom_range(0, 1));
            t.cur_feed_up   = pick_current(1'b0);
        end
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register defaults: expiry edge at 100, zero speeds
    task automatic test_reset_defaults();
        send_tick(make_tick(16'd100, 16'd0, SPEED_LOW, FIRE_HOLD, 2'd0, 16'sd0, 16'sd0));
        send_tick(make_tick(16'd101, 16'd0, SPEED_HIGH, FIRE_HOLD, 2'd0, 16'sd0, 16'sd0));
        send_tick(make_tick(16'd0, 16'd0, SPEED_STOP, FIRE_HOLD, 2'd0, 16'sd9, 16'sd0));
    endtask

    // Walk every state and branch by hand
    task automatic test_state_walk();
        load_regs(16'd1234, 16'h7FFF, 16'd100, 16'd50,
                  16'h8000, 16'd7, 16'h7FFF);
        // spin-up to feed locked, threshold edges on the currents
        send_tick(make_tick(16'd0, 16'd50, SPEED_LOW, FIRE_HOLD, 2'd0, 16'sd0, 16'sd0));
        send_tick(make_tick(16'd0, 16'hFFFF, SPEED_HIGH, FIRE_HOLD, 2'd0, 16'sd10, 16'sd0));
        send_tick(make_tick(16'd100, 16'd100, SPEED_HIGH, FIRE_HOLD, 2'd0,
                            16'sh8000, 16'sd9));
        // fire with level saturation, then a plain level
        send_tick(make_tick(16'd0, 16'd100, SPEED_HIGH, FIRE_SHOT, 2'd3, 16'sd500, -16'sd9));
        send_tick(make_tick(16'd0, 16'd100, SPEED_HIGH, FIRE_SHOT, 2'd1, 16'sd500, 16'sd0));
        // feeding, hold clears the feeder, odd fire code aborts
        send_tick(make_tick(16'd0, 16'd100, SPEED_HIGH, FIRE_SHOT, 2'd0, 16'sd500, 16'sd10));
        send_tick(make_tick(16'd0, 16'd100, SPEED_HIGH, FIRE_SHOT, 2'd2, 16'sd500, -16'sd10));
        send_tick(make_tick(16'd0, 16'd100, SPEED_HIGH, FIRE_HOLD, 2'd2, 16'sh7FFF,
                            16'sh7FFF));
        send_tick(make_tick(16'd0, 16'd100, SPEED_HIGH, FIRE_ODD, 2'd0, 16'sd500, 16'sd300));
        // undefined: feeder clear, wheel clear, back to wheels locked
        send_tick(make_tick(16'd0, 16'd100, SPEED_HIGH, FIRE_HOLD, 2'd0, 16'sd500, 16'sd300));
        send_tick(make_tick(16'd0, 16'd100, SPEED_LOW, FIRE_HOLD, 2'd0, 16'sd500, 16'sd0));
        send_tick(make_tick(16'd0, 16'd100, SPEED_LOW, FIRE_HOLD, 2'd0, 16'sd0, 16'sd0));
        // odd speed keeps the setpoint, high loads it, feeder in lock aborts
        send_tick(make_tick(16'd0, 16'd100, SPEED_ODD, FIRE_HOLD, 2'd0, 16'sd0, 16'sd0));
        send_tick(make_tick(16'd0, 16'd100, SPEED_HIGH, FIRE_HOLD, 2'd0, 16'sd0, 16'sd0));
        send_tick(make_tick(16'd0, 16'd100, SPEED_HIGH, FIRE_HOLD, 2'd0, 16'sd0, 16'sd200));
        // safe path: stale command, then low heat in feed locked
        send_tick(make_tick(16'hFFFF, 16'd100, SPEED_HIGH, FIRE_HOLD, 2'd0, 16'sd0,
                            16'sd200));
        send_tick(make_tick(16'd101, 16'd0, SPEED_LOW, FIRE_HOLD, 2'd0, 16'sd0, 16'sd0));
        send_tick(make_tick(16'd0, 16'd100, SPEED_LOW, FIRE_HOLD, 2'd0, 16'sd50, 16'sd0));
        send_tick(make_tick(16'd0, 16'd100, SPEED_LOW, FIRE_HOLD, 2'd0, 16'sd50, 16'sd0));
        send_tick(make_tick(16'd0, 16'd49, SPEED_LOW, FIRE_SHOT, 2'd0, 16'sd50, 16'sd0));
        send_tick(make_tick(16'd0, 16'd100, SPEED_LOW, FIRE_HOLD, 2'd0, 16'sd50, 16'sd0));
        send_tick(make_tick(16'd0, 16'd100, SPEED_LOW, FIRE_ODD_HI, 2'd0, 16'sd50, 16'sd0));
        // stop request from undefined
        send_tick(make_tick(16'd0, 16'd100, SPEED_STOP, FIRE_HOLD, 2'd0, 16'sd0, 16'sd0));
    endtask

    task automatic test_random_traffic(input int count);
        load_regs(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom()), 16'($urandom()), 16'($urandom()));
        repeat (count) send_tick(random_tick());
    endtask

    // Back-to-back transactions on both sides
    task automatic test_quiet_stream();
        gaps_on = 1'b0;
        repeat (100) send_tick(random_tick());
        gaps_on = 1'b1;
    endtask

    // Results held off while ticks keep coming, so the input stalls
    task automatic test_result_backpressure();
        hold_results = 1'b1;
        repeat (40) send_tick(random_tick());
    endtask

    // Register extremes, including masking of the 15-bit speeds
    task automatic test_register_extremes();
        load_regs(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                  16'h8000, 16'h0000, 16'h7FFF);
        repeat (120) send_tick(random_tick());
        load_regs(16'h0000, 16'h7FFF, 16'h0000, 16'hFFFF,
                  16'h7FFF, 16'hFFFF, 16'h8000);
        repeat (60) send_tick(random_tick());
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LOW_SPEED;
        cfg_data  = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_state_walk();
        test_random_traffic(250);
        test_quiet_stream();
        test_result_backpressure();
        test_register_extremes();
        test_random_traffic(150);

        s_valid <= 1'b0;
        while (due_status.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("run covered %0d command ticks (%0d on the reduced path), %0d results, %0d writes",
                 n_ticks, n_safe, n_results, n_writes);
        $display("states seen: wheel lock %0d, wheel run %0d, feed lock %0d, feeding %0d, undef %0d; %0d mismatches",
                 state_hits[0], state_hits[1], state_hits[2], state_hits[3], state_hits[4],
                 mismatches);
        if (mismatches == 0) begin
            $display("launcher_spin_feed_sequencer_top_tb passed");
        end else begin
            $display("launcher_spin_feed_sequencer_top_tb failed");
        end
        $finish;
    end

endmodule
